// ===== src/drq_pkg.sv =====
// ---------------------------------------------------------------------------
// drq_pkg: shared types and constants
// Field widths, register indexes, item codes and the sequencer states of
// the deduplicating, rate-limited report queue.
// ---------------------------------------------------------------------------
`default_nettype none

package drq_pkg;

  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 32;
  localparam int DBM_W    = 8;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int SEEN_DEPTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [TIME_W-1:0] SEEN_TIMEOUT_RST    = TIME_W'(60000);
  localparam logic [TIME_W-1:0] REPORT_INTERVAL_RST = TIME_W'(5000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEEN_TIMEOUT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = CFG_IDX_W'(1);

  // item codes
  localparam logic FUNC_DETECT = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // lookup broadcast to every seen cell
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] timeout;
  } probe_t;

  // one queued detection
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DBM_W-1:0]  dbm;
    logic [KIND_W-1:0] kind;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/drq_seen_cell.sv =====
// ---------------------------------------------------------------------------
// drq_seen_cell: one entry of the seen store
// Holds an address and its stamp, takes its neighbor's entry on a shift and
// flags a match when the probe address is present and still recent.
// ---------------------------------------------------------------------------
`default_nettype none

module drq_seen_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         shift,
  input  wire logic [drq_pkg::ADDR_W-1:0]   addr_in,
  input  wire logic [drq_pkg::TIME_W-1:0]   stamp_in,
  input  wire drq_pkg::probe_t              probe,
  output logic      [drq_pkg::ADDR_W-1:0]   addr_out,
  output logic      [drq_pkg::TIME_W-1:0]   stamp_out,
  output logic                              hit
);
  import drq_pkg::*;

  logic [TIME_W-1:0] age;

  // cleared entries are real: address zero stamped at time zero
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_out  <= '0;
      stamp_out <= '0;
    end else if (shift) begin
      addr_out  <= addr_in;
      stamp_out <= stamp_in;
    end
  end

  assign age = probe.now - stamp_out;
  assign hit = (addr_out == probe.addr) && (age < probe.timeout);

endmodule

`default_nettype wire

// ===== src/drq_seen_chain.sv =====
// ---------------------------------------------------------------------------
// drq_seen_chain: seen store as a row of cells
// New addresses enter at the first cell and every entry moves one cell on;
// the oldest falls off the end. All cells compare against the probe at once.
// ---------------------------------------------------------------------------
`default_nettype none

module drq_seen_chain #(
  parameter int SEEN_DEPTH = drq_pkg::SEEN_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         insert,
  input  wire drq_pkg::probe_t              probe,
  output logic                              seen_hit
);
  import drq_pkg::*;

  logic [ADDR_W-1:0]     addr_link  [SEEN_DEPTH];
  logic [TIME_W-1:0]     stamp_link [SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0] hits;

  for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] a_in;
    logic [TIME_W-1:0] s_in;

    if (i == 0) begin : g_head
      assign a_in = probe.addr;
      assign s_in = probe.now;
    end else begin : g_body
      assign a_in = addr_link[i-1];
      assign s_in = stamp_link[i-1];
    end

    drq_seen_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (insert),
      .addr_in   (a_in),
      .stamp_in  (s_in),
      .probe     (probe),
      .addr_out  (addr_link[i]),
      .stamp_out (stamp_link[i]),
      .hit       (hits[i])
    );
  end

  assign seen_hit = |hits;

endmodule

`default_nettype wire

// ===== src/drq_queue.sv =====
// ---------------------------------------------------------------------------
// drq_queue: ring queue of detections
// Head and tail pointers over a one-write, one-read memory; a push into a
// full queue drops the oldest entry. Read data is registered at the tail.
// ---------------------------------------------------------------------------
`default_nettype none

module drq_queue #(
  parameter int QUEUE_DEPTH = drq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire drq_pkg::entry_t push_data,
  input  wire logic           pop,
  output logic                empty,
  output drq_pkg::entry_t     rd_data
);
  import drq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;

  assign head_inc = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);
  assign empty    = (head == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (push) begin
      head <= head_inc;
      // drop the oldest entry when full
      if (head_inc == tail) begin
        tail <= tail_inc;
      end
    end else if (pop) begin
      tail <= tail_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[head] <= push_data;
    end
    rd_data <= mem[tail];
  end

endmodule

`default_nettype wire

// ===== src/dedup_rate_limited_report_queue_unit.sv =====
// ---------------------------------------------------------------------------
// dedup_rate_limited_report_queue_unit: deduplicating report queue
// Each item is registered, then looked up in the seen cell row while the
// row, the queue and the report timer are updated. A new item is taken
// only after the last one is done, which waits while a due report is held
// back by a stalled output register. Synchronous reset clears the seen cells to
// address zero at time zero, empties the queue and restores the registers.
// ---------------------------------------------------------------------------
`default_nettype none

module dedup_rate_limited_report_queue_unit #(
  parameter int SEEN_DEPTH  = drq_pkg::SEEN_DEPTH_DEF,
  parameter int QUEUE_DEPTH = drq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              func,
  input  wire logic        [drq_pkg::TIME_W-1:0] now_ms,
  input  wire logic        [drq_pkg::ADDR_W-1:0] device_addr,
  input  wire logic signed [drq_pkg::DBM_W-1:0]  signal_dbm,
  input  wire logic        [drq_pkg::KIND_W-1:0] detect_kind,
  // report channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [drq_pkg::ADDR_W-1:0] report_addr,
  output logic signed      [drq_pkg::DBM_W-1:0]  report_dbm,
  output logic             [drq_pkg::KIND_W-1:0] report_kind,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [drq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [drq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import drq_pkg::*;

  state_t            state;
  state_t            state_next;

  logic [TIME_W-1:0] seen_timeout;
  logic [TIME_W-1:0] report_interval;
  logic [TIME_W-1:0] last_report;

  logic              func_q;
  logic [TIME_W-1:0] now_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DBM_W-1:0]  dbm_q;
  logic [KIND_W-1:0] kind_q;

  probe_t            probe;
  entry_t            push_data;
  entry_t            rd_data;
  logic              seen_hit;
  logic              empty;
  logic [TIME_W-1:0] since_report;
  logic              emit;
  logic              out_busy;
  logic              exec_done;
  logic              insert;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_timeout    <= SEEN_TIMEOUT_RST;
      report_interval <= REPORT_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEEN_TIMEOUT:    seen_timeout    <= cfg_data;
        REG_REPORT_INTERVAL: report_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the accepted item for the update cycle
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q <= func;
      now_q  <= now_ms;
      addr_q <= device_addr;
      dbm_q  <= signal_dbm;
      kind_q <= detect_kind;
    end
  end

  assign probe.addr    = addr_q;
  assign probe.now     = now_q;
  assign probe.timeout = seen_timeout;

  assign push_data.addr = addr_q;
  assign push_data.dbm  = dbm_q;
  assign push_data.kind = kind_q;

  drq_seen_chain #(
    .SEEN_DEPTH (SEEN_DEPTH)
  ) u_seen (
    .clk      (clk),
    .rst      (rst),
    .insert   (insert),
    .probe    (probe),
    .seen_hit (seen_hit)
  );

  drq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (insert),
    .push_data (push_data),
    .pop       (pop),
    .empty     (empty),
    .rd_data   (rd_data)
  );

  assign since_report = now_q - last_report;
  assign out_busy     = out_valid && out_stall;
  assign emit = (state == ST_EXEC) && (func_q == FUNC_POLL) &&
                (since_report >= report_interval) && !empty;
  // a report waits in place while the output register is still held
  assign exec_done = !(emit && out_busy);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: if (exec_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    insert   = 1'b0;
    pop      = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: begin
        insert = (func_q == FUNC_DETECT) && !seen_hit;
        pop    = emit && !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_report <= '0;
      out_valid   <= 1'b0;
    end else if (pop) begin
      last_report <= now_q;
      out_valid   <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      report_addr <= rd_data.addr;
      report_dbm  <= $signed(rd_data.dbm);
      report_kind <= rd_data.kind;
    end
  end

endmodule

`default_nettype wire

// ===== src/drq_checker.sv =====
// ---------------------------------------------------------------------------
// drq_checker: port-level checks for the report queue
// Watches the item and report channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

module drq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [drq_pkg::ADDR_W-1:0] report_addr
);

  // one item at a time: a transfer closes the item port for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item port open right after a transfer");

  // a fresh report is registered from the update state of the poll that asked for it
  a_report_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("report appeared without a poll two cycles earlier");

  // reset leaves no report pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("report valid after reset");

  // a held report keeps its address
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(report_addr))
    else $error("stalled report changed");

endmodule

bind dedup_rate_limited_report_queue_unit drq_checker u_drq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .report_addr (report_addr)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: dedup_rate_limited_report_queue_unit
// The stimulus is a short directed run followed by random detections and
// polls over several register settings and idle patterns. A scoreboard
// keeps a private copy of the seen ring, the report queue and the report
// timer. Every report is checked field by field against the oldest
// predicted report.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import drq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int POOL_SIZE = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  class report_scoreboard;
    logic [TIME_W-1:0] timeout_ms;
    logic [TIME_W-1:0] interval_ms;
    logic [ADDR_W-1:0] seen_addr [SEEN_DEPTH_DEF];
    logic [TIME_W-1:0] seen_time [SEEN_DEPTH_DEF];
    int                seen_wr;
    entry_t            slots [QUEUE_DEPTH_DEF];
    int                head;
    int                tail;
    logic [TIME_W-1:0] last_report_ms;
    entry_t            due_reports [$];
    int                errors;

    function new();
      timeout_ms = SEEN_TIMEOUT_RST;
      interval_ms = REPORT_INTERVAL_RST;
      foreach (seen_addr[i]) begin
        seen_addr[i] = '0;
        seen_time[i] = '0;
      end
      seen_wr = 0;
      head = 0;
      tail = 0;
      last_report_ms = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SEEN_TIMEOUT: timeout_ms = data;
        REG_REPORT_INTERVAL: interval_ms = data;
        default: ;
      endcase
    endfunction

    function void note_item(logic f, logic [TIME_W-1:0] now, logic [ADDR_W-1:0] addr,
                            logic [DBM_W-1:0] dbm, logic [KIND_W-1:0] kind);
      logic [TIME_W-1:0] age;
      bit                recent;
      int                nxt;
      recent = 1'b0;
      if (f == FUNC_POLL) begin
        age = now - last_report_ms;
        if (age >= interval_ms && head != tail) begin
          due_reports.push_back(slots[tail]);
          last_report_ms = now;
          tail = (tail + 1) % QUEUE_DEPTH_DEF;
        end
        return;
      end
      foreach (seen_addr[i]) begin
        age = now - seen_time[i];
        if (seen_addr[i] == addr && age < timeout_ms) recent = 1'b1;
      end
      if (recent) return;
      seen_addr[seen_wr] = addr;
      seen_time[seen_wr] = now;
      seen_wr = (seen_wr + 1) % SEEN_DEPTH_DEF;
      // drop the oldest entry when full
      nxt = (head + 1) % QUEUE_DEPTH_DEF;
      if (nxt == tail) tail = (tail + 1) % QUEUE_DEPTH_DEF;
      slots[head].addr = addr;
      slots[head].dbm = dbm;
      slots[head].kind = kind;
      head = nxt;
    endfunction

    function void check_report(logic [ADDR_W-1:0] addr, logic [DBM_W-1:0] dbm,
                               logic [KIND_W-1:0] kind);
      entry_t want;
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: expected none, got addr %h dbm %0d kind %0d",
                 $time, addr, $signed(dbm), kind);
        return;
      end
      want = due_reports.pop_front();
      if (want.addr !== addr) begin
        errors++;
        $display("%0t: report_addr: expected %h, got %h", $time, want.addr, addr);
      end
      if (want.dbm !== dbm) begin
        errors++;
        $display("%0t: report_dbm: expected %0d, got %0d", $time, $signed(want.dbm),
                 $signed(dbm));
      end
      if (want.kind !== kind) begin
        errors++;
        $display("%0t: report_kind: expected %0d, got %0d", $time, want.kind, kind);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     func;
  logic        [TIME_W-1:0] now_ms;
  logic        [ADDR_W-1:0] device_addr;
  logic signed [DBM_W-1:0]  signal_dbm;
  logic        [KIND_W-1:0] detect_kind;
  logic                     out_valid;
  logic                     out_stall;
  logic        [ADDR_W-1:0] report_addr;
  logic signed [DBM_W-1:0]  report_dbm;
  logic        [KIND_W-1:0] report_kind;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  report_scoreboard  sb = new();
  int                send_idle = 0;
  int                recv_stall = 0;
  int                cycle_count = 0;
  logic [TIME_W-1:0] clock_ms;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  dedup_rate_limited_report_queue_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .now_ms      (now_ms),
    .device_addr (device_addr),
    .signal_dbm  (signal_dbm),
    .detect_kind (detect_kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .report_addr (report_addr),
    .report_dbm  (report_dbm),
    .report_kind (report_kind),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall);
  end

  // every transfer is seen here, on the values that held before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        sb.note_item(func, now_ms, device_addr, signal_dbm, detect_kind);
      end
      if (out_valid && !out_stall) sb.check_report(report_addr, report_dbm, report_kind);
    end
  end

  task automatic send_item(logic f, logic [TIME_W-1:0] now, logic [ADDR_W-1:0] addr,
                           logic [DBM_W-1:0] dbm, logic [KIND_W-1:0] kind);
    in_valid <= 1'b1;
    func <= f;
    now_ms <= now;
    device_addr <= addr;
    signal_dbm <= dbm;
    detect_kind <= kind;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_idle();
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic send_random(int step_max);
    logic [ADDR_W-1:0] addr;
    logic              f;
    f = ($urandom_range(99) < 45) ? FUNC_POLL : FUNC_DETECT;
    // mostly revisit a small address pool so duplicates and evictions occur
    if ($urandom_range(99) < 60) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
    else addr = ADDR_W'({$urandom(), $urandom()});
    if ($urandom_range(99) < 2) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(step_max);
    send_item(f, clock_ms, addr, DBM_W'($urandom()), KIND_W'($urandom()));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait for the block to drain and finish any update in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [TIME_W-1:0] timeout, logic [TIME_W-1:0] interval,
                           int step_max, int count, int idle_mode);
    settle();
    write_reg(REG_SEEN_TIMEOUT, timeout);
    write_reg(REG_REPORT_INTERVAL, interval);
    if ($urandom_range(1)) write_reg(REG_UNMAPPED - CFG_IDX_W'($urandom_range(253)), $urandom());
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idle_mode)
      0: begin send_idle = 0; recv_stall = 0; end
      1: begin send_idle = 59; recv_stall = 0; end
      2: begin send_idle = 0; recv_stall = 59; end
      default: begin send_idle = 34; recv_stall = 34; end
    endcase
    repeat (count) begin
      send_random(step_max);
      sender_idle();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_DETECT;
    now_ms <= '0;
    device_addr <= '0;
    signal_dbm <= '0;
    detect_kind <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SEEN_TIMEOUT;
    cfg_data <= '0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
    clock_ms = 32'd90000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero address is already seen at time zero until the timeout passes
    send_item(FUNC_DETECT, 32'd0, '0, 8'sd5, 3'd1);
    send_item(FUNC_POLL, 32'd100, '0, '0, '0);
    send_item(FUNC_DETECT, 32'd60000, '0, '0, '0);
    send_item(FUNC_POLL, 32'd65000, '0, '0, '0);
    // interval passed but nothing queued: timer must hold
    send_item(FUNC_POLL, 32'd70500, '0, '0, '0);
    send_item(FUNC_DETECT, 32'd70501, '1, -8'sd128, 3'd7);
    send_item(FUNC_POLL, 32'd66000, '0, '0, '0);
    send_item(FUNC_DETECT, 32'd70503, '1, 8'sd127, 3'd6);
    // overfill the queue so the oldest entry is dropped
    for (int k = 0; k < 15; k++) begin
      send_item(FUNC_DETECT, 32'd71000 + 32'(k), {16'hA5A5, 32'(k)},
                (k % 2) ? 8'sd127 : -8'sd1, KIND_W'(k));
    end
    send_item(FUNC_POLL, 32'd80000, '0, '0, '0);
    send_item(FUNC_POLL, 32'd80001, '0, '0, '0);

    run_phase(SEEN_TIMEOUT_RST, REPORT_INTERVAL_RST, 3000, 220, 0);
    run_phase('0, '0, 50, 220, 1);
    run_phase('1, '1, 2000, 120, 2);
    run_phase(32'd300, 32'd150, 120, 220, 3);
    run_phase(32'd5000, 32'd1, 400, 220, 0);
    run_phase(32'd1, 32'd2000, 500, 220, 1);
    run_phase(32'd100000, '0, 5000, 200, 2);
    run_phase(32'd40, 32'd20, 30, 260, 3);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/drq_pkg.sv
src/drq_seen_cell.sv
src/drq_seen_chain.sv
src/drq_queue.sv
src/dedup_rate_limited_report_queue_unit.sv
src/drq_checker.sv
dv/testbench.sv
